// ===== rtl/core/xpes_pkg.sv =====
// ============================================================================
// xpes_pkg
// Shared types and constants of the XM pattern effect scanner.
// ============================================================================
package xpes_pkg;

    localparam int NORMAL_W  = 36;
    localparam int SPECIAL_W = 16;
    localparam int FIELD_W   = 5;

    // Bit 7 of a cell's first byte marks a packed cell.
    localparam int FLAG_BIT = 7;

    // Presence mask of a cell whose first byte is the note itself.
    localparam logic [FIELD_W-1:0] FIELDS_AFTER_NOTE = 5'b11110;
    localparam logic [FIELD_W-1:0] FIELD_VOLUME      = 5'b00100;
    localparam logic [FIELD_W-1:0] FIELD_EFFECT      = 5'b01000;
    localparam logic [FIELD_W-1:0] FIELD_PARAM       = 5'b10000;

    // Effect numbers with special handling.
    localparam logic [7:0] EFF_ARPEGGIO    = 8'd0;
    localparam logic [7:0] EFF_PORTA_UP    = 8'd1;
    localparam logic [7:0] EFF_PORTA_DOWN  = 8'd2;
    localparam logic [7:0] EFF_E_COMMAND   = 8'd14;
    localparam logic [7:0] EFF_GLOBAL_VOL  = 8'd17;
    localparam logic [7:0] EFF_MULTI_RETRG = 8'd27;
    localparam logic [7:0] EFF_EXTRA_FINE  = 8'd33;
    localparam logic [7:0] EFF_LAST        = 8'd35;

    // E-subcommands that do nothing with a zero argument.
    localparam logic [3:0] SUB_FINE_UP    = 4'd1;
    localparam logic [3:0] SUB_FINE_DOWN  = 4'd2;
    localparam logic [3:0] SUB_RETRIG     = 4'd9;
    localparam logic [3:0] SUB_FVOL_UP    = 4'd10;
    localparam logic [3:0] SUB_FVOL_DOWN  = 4'd11;

    // Extra-fine porta subcommands that count as used.
    localparam logic [3:0] XF_UP   = 4'd1;
    localparam logic [3:0] XF_DOWN = 4'd2;

    // One finished cell, as passed from the parser to the bitmap stage.
    typedef struct packed {
        logic       clr;      // clear bitmaps before applying this cell
        logic       vol_nz;   // volume byte was nonzero
        logic [7:0] effect;
        logic [7:0] param;
    } t_cell;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/core/xpes_if.sv =====
// ============================================================================
// xpes_if
// Valid/ready channels of the XM pattern effect scanner.
// ============================================================================
interface xpes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       clear_flags;

    modport source (output valid, output data_byte, output clear_flags, input ready);
    modport sink   (input valid, input data_byte, input clear_flags, output ready);
endinterface

interface xpes_out_if;
    logic        valid;
    logic        ready;
    logic [35:0] normal_used;
    logic [15:0] special_used;
    logic        volume_used;

    modport source (output valid, output normal_used, output special_used,
                    output volume_used, input ready);
    modport sink   (input valid, input normal_used, input special_used,
                    input volume_used, output ready);
endinterface

// ===== rtl/core/xm_pattern_effect_scanner_core.sv =====
// ============================================================================
// xm_pattern_effect_scanner_core
// Scans packed XM pattern cell bytes and reports the effects in use.
// ============================================================================
// Feed the packed cell bytes of XM patterns, headers removed, one word per
// byte on i_in. Each time a cell completes, one result word leaves on o_res
// holding the running bitmaps of used effects (0..35), used E-subcommands and
// a flag for any nonzero volume byte. Bytes inside a cell produce no result.
// Set clear_flags with a byte to zero the bitmaps and the parse state before
// that byte; it then starts a new cell. The block takes one byte per cycle
// while the queue is not full: the parser decides each byte combinationally
// and pushes finished cells into a two-entry queue, and the bitmap stage
// applies one cell per cycle into the output register unless o_res stalls.
// A finished cell is queued, then registered. i_in.ready drops only while
// the queue is full, which happens only when o_res is held stalled.
// ============================================================================
module xm_pattern_effect_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xpes_in_if.sink     i_in,
    xpes_out_if.source  o_res
);

    xpes_pkg::t_cell         w_push_cell;
    xpes_pkg::t_cell         w_pop_cell;
    xpes_pkg::t_queue_status w_qstat;
    logic                    w_push;
    logic                    w_pop;

    // Parse bytes and emit finished cells.
    xpes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_cell  (w_push_cell)
    );

    // Decouple the parser from output stalls.
    xpes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cell  (w_push_cell),
        .i_pop   (w_pop),
        .o_cell  (w_pop_cell),
        .o_stat  (w_qstat)
    );

    // Fold cells into the bitmaps and hold the result word.
    xpes_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (w_pop_cell),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    // A used E-subcommand implies effect 14 itself is marked.
    a_special_implies_e: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.special_used == '0 || o_res.normal_used[14]))
        else $error("special bitmap set without effect 14");

    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("cell pushed into full queue");

    // Only a queued cell may be popped.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("cell popped from empty queue");
`endif

endmodule

// ===== rtl/core/xpes_front.sv =====
// ============================================================================
// xpes_front
// Byte parser: tracks pending cell fields and pushes each finished cell.
// ============================================================================
module xpes_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    xpes_in_if.sink                i_in,
    input  xpes_pkg::t_queue_status i_qstat,
    output logic                   o_push,
    output xpes_pkg::t_cell        o_cell
);

    logic [xpes_pkg::FIELD_W-1:0] r_pending, n_pending;
    logic                         r_clr_pend;
    logic                         r_vol_nz, n_vol_nz;
    logic [7:0]                   r_effect, n_effect;
    logic [7:0]                   r_param, n_param;

    logic [xpes_pkg::FIELD_W-1:0] w_pend;
    logic [xpes_pkg::FIELD_W-1:0] w_low;
    logic                         w_accept;
    logic                         w_done;

    assign i_in.ready = ~i_qstat.full;
    assign w_accept   = i_in.valid & i_in.ready;

    always_comb begin
        w_pend    = i_in.clear_flags ? '0 : r_pending;
        w_low     = w_pend & (~w_pend + xpes_pkg::FIELD_W'(1));
        n_vol_nz  = r_vol_nz;
        n_effect  = r_effect;
        n_param   = r_param;
        n_pending = w_pend & ~w_low;
        if (w_pend == '0) begin
            // start of a cell: fields default to zero
            n_vol_nz = 1'b0;
            n_effect = '0;
            n_param  = '0;
            if (i_in.data_byte[xpes_pkg::FLAG_BIT]) begin
                n_pending = i_in.data_byte[xpes_pkg::FIELD_W-1:0];
            end else begin
                n_pending = xpes_pkg::FIELDS_AFTER_NOTE;
            end
        end else begin
            if (w_low == xpes_pkg::FIELD_VOLUME) begin
                n_vol_nz = (i_in.data_byte != 8'd0);
            end
            if (w_low == xpes_pkg::FIELD_EFFECT) begin
                n_effect = i_in.data_byte;
            end
            if (w_low == xpes_pkg::FIELD_PARAM) begin
                n_param = i_in.data_byte;
            end
        end
        w_done = (n_pending == '0);
    end

    assign o_push        = w_accept & w_done;
    assign o_cell.clr    = r_clr_pend | i_in.clear_flags;
    assign o_cell.vol_nz = n_vol_nz;
    assign o_cell.effect = n_effect;
    assign o_cell.param  = n_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_clr_pend <= 1'b0;
        end else if (w_accept) begin
            r_pending  <= n_pending;
            // carry a clear until the cell that delivers it
            r_clr_pend <= w_done ? 1'b0 : (r_clr_pend | i_in.clear_flags);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vol_nz <= n_vol_nz;
            r_effect <= n_effect;
            r_param  <= n_param;
        end
    end

endmodule

// ===== rtl/core/xpes_queue.sv =====
// ============================================================================
// xpes_queue
// Two-entry cell queue between the parser and the bitmap stage.
// ============================================================================
module xpes_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  xpes_pkg::t_cell         i_cell,
    input  logic                    i_pop,
    output xpes_pkg::t_cell         o_cell,
    output xpes_pkg::t_queue_status o_stat
);

    xpes_pkg::t_cell r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_cell       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/xpes_back.sv =====
// ============================================================================
// xpes_back
// Bitmap stage: applies each finished cell and registers the result word.
// ============================================================================
module xpes_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  xpes_pkg::t_cell         i_cell,
    input  xpes_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    xpes_out_if.source              o_res
);

    logic                           r_valid;
    logic [xpes_pkg::NORMAL_W-1:0]  r_normal, n_normal;
    logic [xpes_pkg::SPECIAL_W-1:0] r_special, n_special;
    logic                           r_volume, n_volume;

    logic [3:0] w_hi;
    logic       w_skip;
    logic       w_needs_arg;

    assign o_pop = ~i_qstat.empty & (~r_valid | o_res.ready);

    always_comb begin
        w_hi   = i_cell.param[7:4];
        w_skip = 1'b0;
        if (i_cell.effect == xpes_pkg::EFF_ARPEGGIO && i_cell.param == 8'd0) begin
            w_skip = 1'b1;
        end
        if (i_cell.effect == xpes_pkg::EFF_EXTRA_FINE &&
            w_hi != xpes_pkg::XF_UP && w_hi != xpes_pkg::XF_DOWN) begin
            w_skip = 1'b1;
        end
        if (i_cell.param == 8'd0 &&
            (i_cell.effect == xpes_pkg::EFF_PORTA_UP ||
             i_cell.effect == xpes_pkg::EFF_PORTA_DOWN ||
             i_cell.effect == xpes_pkg::EFF_MULTI_RETRG ||
             i_cell.effect == xpes_pkg::EFF_GLOBAL_VOL)) begin
            w_skip = 1'b1;
        end
        w_needs_arg = (w_hi == xpes_pkg::SUB_FINE_UP) || (w_hi == xpes_pkg::SUB_FINE_DOWN) ||
                      (w_hi == xpes_pkg::SUB_RETRIG) || (w_hi == xpes_pkg::SUB_FVOL_UP) ||
                      (w_hi == xpes_pkg::SUB_FVOL_DOWN);

        n_normal  = i_cell.clr ? '0 : r_normal;
        n_special = i_cell.clr ? '0 : r_special;
        n_volume  = (i_cell.clr ? 1'b0 : r_volume) | i_cell.vol_nz;
        if (!w_skip && i_cell.effect <= xpes_pkg::EFF_LAST) begin
            n_normal = n_normal | (xpes_pkg::NORMAL_W'(1) << i_cell.effect[5:0]);
        end
        if (!w_skip && i_cell.effect == xpes_pkg::EFF_E_COMMAND &&
            !(w_needs_arg && i_cell.param[3:0] == 4'd0)) begin
            n_special = n_special | (xpes_pkg::SPECIAL_W'(1) << w_hi);
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.normal_used  = r_normal;
    assign o_res.special_used = r_special;
    assign o_res.volume_used  = r_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_normal  <= '0;
            r_special <= '0;
            r_volume  <= 1'b0;
        end else if (o_pop) begin
            r_valid   <= 1'b1;
            r_normal  <= n_normal;
            r_special <= n_special;
            r_volume  <= n_volume;
        end else if (o_res.ready) begin
            r_valid   <= 1'b0;
        end
    end

endmodule
